FILE: hdl/quad_grid_point_generator_defines.svh
// ----------------------------------------------------------------------------
// Quad grid point generator assertion macros
// Shorthand for the clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef QUAD_GRID_POINT_GENERATOR_DEFINES_SVH
`define QUAD_GRID_POINT_GENERATOR_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define QGPG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define QGPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/qgpg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgpg_pkg
// Types, constants and saturating helpers shared by the grid point generator.
// ----------------------------------------------------------------------------
package qgpg_pkg;

   localparam int MAX_COLS = 8;
   localparam int MAX_ROWS = 8;
   localparam int CNT_W    = 4;
   localparam int IDX_W    = $clog2(MAX_COLS);
   localparam int OP_W     = 64;
   localparam int STEP_W   = $clog2(OP_W);

   localparam logic [2:0] CSR_COLS_ADDR = 3'h0;
   localparam logic [2:0] CSR_ROWS_ADDR = 3'h4;

   localparam logic signed [63:0] MAX64 = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MIN64 = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] c_x;
      logic signed [31:0] c_y;
      logic signed [31:0] d_x;
      logic signed [31:0] d_y;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               failed;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic [63:0] num_hi;
      logic [63:0] num_lo;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quot;
   } div_rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_SETUP, S_SLOAD, S_SMP0, S_SMPW, S_SMP2, S_SMPM, S_SMPN,
      S_FIT0, S_FITD, S_FITS, S_FITM, S_STORE, S_PT0, S_PTD, S_PTS, S_PTM
   } state_type;

   typedef enum logic [1:0] {PH_EDGE, PH_COL, PH_ROW, PH_PT} phase_type;

   function automatic logic signed [63:0] from_sm(input logic neg, input logic [63:0] m);
      logic signed [63:0] r;
      if (!neg) begin
         r = m[63] ? MAX64 : $signed(m);
      end else if (m[63]) begin
         r = MIN64;
      end else begin
         r = -$signed(m);
      end
      return r;
   endfunction

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? MIN64 : MAX64;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? MIN64 : MAX64;
      return s[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v[63:31] == {33{v[63]}}) return v[31:0];
      return v[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
   endfunction

   function automatic logic signed [63:0] sext32(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] lim);
      if (v == '0) return CNT_W'(1);
      if (v > lim) return lim;
      return v;
   endfunction

endpackage

FILE: hdl/qgpg_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgpg_mul
// Bit-serial signed multiply, result (a*b)>>32 truncated and saturated.
// ----------------------------------------------------------------------------
module qgpg_mul
   import qgpg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   logic [63:0]        ua_ff, ua_in;
   logic [63:0]        ub_ff, ub_in;
   logic [127:0]       acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic signed [63:0] res_ff, res_in;
   logic [64:0]        sum;

   always_comb begin
      ua_in   = ua_ff;
      ub_in   = ub_ff;
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      res_in  = res_ff;
      sum     = {1'b0, acc_ff[127:64]} + (ub_ff[0] ? {1'b0, ua_ff} : 65'd0);
      if (req.start) begin
         ua_in  = req.a[63] ? 64'(-req.a) : req.a;
         ub_in  = req.b[63] ? 64'(-req.b) : req.b;
         neg_in = req.a[63] ^ req.b[63];
         acc_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         // add the multiplicand into the top half, then shift right
         acc_in = {sum, acc_ff[63:1]};
         ub_in  = ub_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(OP_W - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (fin_ff) begin
         done_in = 1'b1;
         if (acc_ff[127:96] != '0) begin
            res_in = neg_ff ? MIN64 : MAX64;
         end else begin
            res_in = from_sm(neg_ff, acc_ff[95:32]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      ua_ff  <= ua_in;
      ub_ff  <= ub_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = res_ff;

endmodule

FILE: hdl/qgpg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgpg_div
// Restoring divider, one quotient bit per cycle, 128 by 64 bits unsigned.
// ----------------------------------------------------------------------------
module qgpg_div
   import qgpg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [63:0]       den_ff, den_in;
   logic [63:0]       rem_ff, rem_in;
   logic [63:0]       lo_ff, lo_in;
   logic [63:0]       q_ff, q_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [64:0]       rs;
   logic [64:0]       diff;
   logic              take;

   always_comb begin
      den_in  = den_ff;
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      rs      = {rem_ff, lo_ff[63]};
      diff    = rs - {1'b0, den_ff};
      take    = (rs >= {1'b0, den_ff});
      if (req.start) begin
         den_in = req.den;
         cnt_in = '0;
         if (req.den == '0 || req.num_hi >= req.den) begin
            // quotient overflows: saturate
            q_in    = '1;
            done_in = 1'b1;
         end else begin
            rem_in = req.num_hi;
            lo_in  = req.num_lo;
            q_in   = '0;
            run_in = 1'b1;
         end
      end else if (run_ff) begin
         rem_in = take ? diff[63:0] : rs[63:0];
         q_in   = {q_ff[62:0], take};
         lo_in  = lo_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(OP_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      den_ff <= den_in;
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;

endmodule

FILE: hdl/qgpg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgpg_seq
// Sequencer: edge fits, column and row line fits, then intersections until the last or a failed one.
// ----------------------------------------------------------------------------
module qgpg_seq
   import qgpg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_item_type     req_item,
   input  logic [CNT_W-1:0] n_cols,
   input  logic [CNT_W-1:0] n_rows,
   output logic             rsp_strobe,
   output rsp_item_type     rsp_item,
   output mul_req_type      mul_req,
   input  mul_rsp_type      mul_rsp,
   output div_req_type      div_req,
   input  div_rsp_type      div_rsp
);

   localparam logic [1:0] EDGE_AB = 2'd0;
   localparam logic [1:0] EDGE_BC = 2'd1;
   localparam logic [1:0] EDGE_DC = 2'd2;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               half_ff, half_in;
   logic [IDX_W-1:0]   c_ff, c_in;
   logic [IDX_W-1:0]   r_ff, r_in;
   req_item_type       cor_ff, cor_in;
   logic [CNT_W-1:0]   nc_ff, nc_in;
   logic [CNT_W-1:0]   nr_ff, nr_in;

   logic signed [63:0] edge_slope_ff [4];
   logic signed [63:0] edge_off_ff   [4];
   logic               edge_vert_ff  [4];
   logic signed [63:0] col_slope_ff  [MAX_COLS];
   logic signed [63:0] col_off_ff    [MAX_COLS];
   logic               col_vert_ff   [MAX_COLS];
   logic signed [63:0] row_slope_ff  [MAX_ROWS];
   logic signed [63:0] row_off_ff    [MAX_ROWS];
   logic               row_vert_ff   [MAX_ROWS];

   logic signed [31:0] fp1x_ff, fp1x_in, fp1y_ff, fp1y_in;
   logic signed [31:0] fp2x_ff, fp2x_in, fp2y_ff, fp2y_in;
   logic signed [63:0] gslope_ff, gslope_in, goff_ff, goff_in;
   logic               gvert_ff, gvert_in;
   logic               fneg_ff, fneg_in;

   logic signed [31:0] sp0x_ff, sp0x_in, sp0y_ff, sp0y_in;
   logic signed [31:0] sp1x_ff, sp1x_in, sp1y_ff, sp1y_in;
   logic signed [63:0] sl_slope_ff, sl_slope_in, sl_off_ff, sl_off_in;
   logic               sl_vert_ff, sl_vert_in;
   logic [IDX_W-1:0]   sk_ff, sk_in;
   logic [CNT_W-1:0]   sn_ff, sn_in;
   logic               lneg_ff, lneg_in;
   logic signed [31:0] lv_ff, lv_in;

   logic signed [63:0] cs_ff, cs_in, co_ff, co_in;
   logic               cv_ff, cv_in;
   logic signed [63:0] rs_ff, rs_in, ro_ff, ro_in;
   logic               rv_ff, rv_in;
   logic signed [63:0] px_ff, px_in, base_ff, base_in;

   logic               rsp_strobe_ff, rsp_strobe_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // edge end points and working values
   logic [1:0]         sel_e;
   logic signed [31:0] e0x, e0y, e1x, e1y;
   logic signed [31:0] v1, v2;
   logic signed [32:0] ldiff;
   logic signed [36:0] lprod;
   logic [36:0]        lmag;
   logic signed [38:0] lq;
   logic signed [38:0] lsum;
   logic signed [32:0] fdy, fdx;
   logic [32:0]        fny, fnx;
   logic signed [64:0] doff, dslp;
   logic [64:0]        noff, nslp;
   logic signed [63:0] py;
   logic               last_pt;

   assign sel_e = (phase_ff == PH_EDGE) ? idx_ff[1:0] : {half_ff, phase_ff == PH_ROW};

   always_comb begin
      case (sel_e)
         EDGE_AB: begin
            e0x = cor_ff.a_x; e0y = cor_ff.a_y; e1x = cor_ff.b_x; e1y = cor_ff.b_y;
         end
         EDGE_BC: begin
            e0x = cor_ff.b_x; e0y = cor_ff.b_y; e1x = cor_ff.c_x; e1y = cor_ff.c_y;
         end
         EDGE_DC: begin
            e0x = cor_ff.d_x; e0y = cor_ff.d_y; e1x = cor_ff.c_x; e1y = cor_ff.c_y;
         end
         default: begin
            e0x = cor_ff.a_x; e0y = cor_ff.a_y; e1x = cor_ff.d_x; e1y = cor_ff.d_y;
         end
      endcase
   end

   always_comb begin
      v1    = sl_vert_ff ? sp0y_ff : sp0x_ff;
      v2    = sl_vert_ff ? sp1y_ff : sp1x_ff;
      ldiff = {v2[31], v2} - {v1[31], v1};
      lprod = $signed({1'b0, sk_ff}) * ldiff;
      lmag  = lprod[36] ? 37'(-lprod) : lprod;
      lq    = lneg_ff ? -$signed({2'b00, div_rsp.quot[36:0]})
                      : $signed({2'b00, div_rsp.quot[36:0]});
      lsum  = {{7{v1[31]}}, v1} + lq;
      fdy   = {fp2y_ff[31], fp2y_ff} - {fp1y_ff[31], fp1y_ff};
      fdx   = {fp2x_ff[31], fp2x_ff} - {fp1x_ff[31], fp1x_ff};
      fny   = fdy[32] ? 33'(-fdy) : fdy;
      fnx   = fdx[32] ? 33'(-fdx) : fdx;
      doff  = {ro_ff[63], ro_ff} - {co_ff[63], co_ff};
      dslp  = {cs_ff[63], cs_ff} - {rs_ff[63], rs_ff};
      noff  = doff[64] ? 65'(-doff) : doff;
      nslp  = dslp[64] ? 65'(-dslp) : dslp;
      py    = sat_add64(mul_rsp.result, base_ff);
      last_pt = ({1'b0, c_ff} == nc_ff - 1'b1) && ({1'b0, r_ff} == nr_ff - 1'b1);
   end

   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      idx_in      = idx_ff;
      half_in     = half_ff;
      c_in        = c_ff;
      r_in        = r_ff;
      cor_in      = cor_ff;
      nc_in       = nc_ff;
      nr_in       = nr_ff;
      fp1x_in     = fp1x_ff;
      fp1y_in     = fp1y_ff;
      fp2x_in     = fp2x_ff;
      fp2y_in     = fp2y_ff;
      gslope_in   = gslope_ff;
      goff_in     = goff_ff;
      gvert_in    = gvert_ff;
      fneg_in     = fneg_ff;
      sp0x_in     = sp0x_ff;
      sp0y_in     = sp0y_ff;
      sp1x_in     = sp1x_ff;
      sp1y_in     = sp1y_ff;
      sl_slope_in = sl_slope_ff;
      sl_off_in   = sl_off_ff;
      sl_vert_in  = sl_vert_ff;
      sk_in       = sk_ff;
      sn_in       = sn_ff;
      lneg_in     = lneg_ff;
      lv_in       = lv_ff;
      cs_in       = cs_ff;
      co_in       = co_ff;
      cv_in       = cv_ff;
      rs_in       = rs_ff;
      ro_in       = ro_ff;
      rv_in       = rv_ff;
      px_in       = px_ff;
      base_in     = base_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      mul_req     = '0;
      div_req     = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cor_in   = req_item;
               nc_in    = n_cols;
               nr_in    = n_rows;
               phase_in = PH_EDGE;
               idx_in   = '0;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            case (phase_ff)
               PH_EDGE: begin
                  fp1x_in  = e0x;
                  fp1y_in  = e0y;
                  fp2x_in  = e1x;
                  fp2y_in  = e1y;
                  state_in = S_FIT0;
               end
               PH_COL, PH_ROW: begin
                  half_in  = 1'b0;
                  state_in = S_SLOAD;
               end
               default: begin
                  cs_in    = col_slope_ff[c_ff];
                  co_in    = col_off_ff[c_ff];
                  cv_in    = col_vert_ff[c_ff];
                  rs_in    = row_slope_ff[r_ff];
                  ro_in    = row_off_ff[r_ff];
                  rv_in    = row_vert_ff[r_ff];
                  state_in = S_PT0;
               end
            endcase
         end
         S_SLOAD: begin
            sp0x_in     = e0x;
            sp0y_in     = e0y;
            sp1x_in     = e1x;
            sp1y_in     = e1y;
            sl_slope_in = edge_slope_ff[sel_e];
            sl_off_in   = edge_off_ff[sel_e];
            sl_vert_in  = edge_vert_ff[sel_e];
            sk_in       = idx_ff;
            sn_in       = (phase_ff == PH_ROW) ? nr_ff : nc_ff;
            state_in    = S_SMP0;
         end
         S_SMP0: begin
            if ({1'b0, sk_ff} >= sn_ff - 1'b1) begin
               // final sample is the edge end point
               lv_in    = v2;
               state_in = S_SMP2;
            end else begin
               lneg_in        = lprod[36];
               div_req.start  = 1'b1;
               div_req.num_hi = '0;
               div_req.num_lo = 64'(lmag);
               div_req.den    = 64'(sn_ff - 1'b1);
               state_in       = S_SMPW;
            end
         end
         S_SMPW: begin
            if (div_rsp.done) begin
               lv_in    = lsum[31:0];
               state_in = S_SMP2;
            end
         end
         S_SMP2: begin
            if (sl_vert_ff) begin
               if (half_ff) begin
                  fp2x_in = sp0x_ff;
                  fp2y_in = lv_ff;
               end else begin
                  fp1x_in = sp0x_ff;
                  fp1y_in = lv_ff;
               end
               state_in = S_SMPN;
            end else begin
               mul_req.start = 1'b1;
               mul_req.a     = sl_slope_ff;
               mul_req.b     = sext32(lv_ff);
               state_in      = S_SMPM;
            end
         end
         S_SMPM: begin
            if (mul_rsp.done) begin
               if (half_ff) begin
                  fp2x_in = lv_ff;
                  fp2y_in = sat32(sat_add64(mul_rsp.result, sl_off_ff));
               end else begin
                  fp1x_in = lv_ff;
                  fp1y_in = sat32(sat_add64(mul_rsp.result, sl_off_ff));
               end
               state_in = S_SMPN;
            end
         end
         S_SMPN: begin
            if (half_ff) begin
               state_in = S_FIT0;
            end else begin
               half_in  = 1'b1;
               state_in = S_SLOAD;
            end
         end
         S_FIT0: begin
            if (fp1x_ff == fp2x_ff) begin
               gvert_in  = 1'b1;
               gslope_in = '0;
               goff_in   = sext32(fp1x_ff);
               state_in  = S_STORE;
            end else begin
               fneg_in        = fdy[32] ^ fdx[32];
               div_req.start  = 1'b1;
               div_req.num_hi = 64'(fny[32]);
               div_req.num_lo = {fny[31:0], 32'd0};
               div_req.den    = 64'(fnx);
               state_in       = S_FITD;
            end
         end
         S_FITD: begin
            if (div_rsp.done) begin
               gslope_in = from_sm(fneg_ff, div_rsp.quot);
               state_in  = S_FITS;
            end
         end
         S_FITS: begin
            mul_req.start = 1'b1;
            mul_req.a     = gslope_ff;
            mul_req.b     = sext32(fp2x_ff);
            state_in      = S_FITM;
         end
         S_FITM: begin
            if (mul_rsp.done) begin
               gvert_in = 1'b0;
               goff_in  = sat_sub64(sext32(fp2y_ff), mul_rsp.result);
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            state_in = S_SETUP;
            case (phase_ff)
               PH_EDGE: begin
                  if (idx_ff[1:0] == 2'd3) begin
                     phase_in = PH_COL;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               PH_COL: begin
                  if ({1'b0, idx_ff} == nc_ff - 1'b1) begin
                     phase_in = PH_ROW;
                     idx_in   = '0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               default: begin
                  if ({1'b0, idx_ff} == nr_ff - 1'b1) begin
                     phase_in = PH_PT;
                     c_in     = '0;
                     r_in     = '0;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            endcase
         end
         S_PT0: begin
            if ((cv_ff && rv_ff) || (!cv_ff && !rv_ff && cs_ff == rs_ff)) begin
               // no single crossing: report and end the run
               rsp_strobe_in       = 1'b1;
               rsp_item_in.point_x = '0;
               rsp_item_in.point_y = '0;
               rsp_item_in.failed  = 1'b1;
               rsp_item_in.last    = 1'b1;
               state_in            = S_IDLE;
            end else if (cv_ff) begin
               px_in         = co_ff;
               base_in       = ro_ff;
               mul_req.start = 1'b1;
               mul_req.a     = rs_ff;
               mul_req.b     = co_ff;
               state_in      = S_PTM;
            end else if (rv_ff) begin
               px_in         = ro_ff;
               base_in       = co_ff;
               mul_req.start = 1'b1;
               mul_req.a     = cs_ff;
               mul_req.b     = ro_ff;
               state_in      = S_PTM;
            end else begin
               fneg_in        = doff[64] ^ dslp[64];
               div_req.start  = 1'b1;
               div_req.num_hi = 64'(noff[63:32]);
               div_req.num_lo = {noff[31:0], 32'd0};
               div_req.den    = nslp[63:0];
               state_in       = S_PTD;
            end
         end
         S_PTD: begin
            if (div_rsp.done) begin
               px_in    = from_sm(fneg_ff, div_rsp.quot);
               base_in  = co_ff;
               state_in = S_PTS;
            end
         end
         S_PTS: begin
            mul_req.start = 1'b1;
            mul_req.a     = cs_ff;
            mul_req.b     = px_ff;
            state_in      = S_PTM;
         end
         S_PTM: begin
            if (mul_rsp.done) begin
               rsp_strobe_in       = 1'b1;
               rsp_item_in.point_x = sat32(px_ff);
               rsp_item_in.point_y = sat32(py);
               rsp_item_in.failed  = 1'b0;
               rsp_item_in.last    = last_pt;
               if (last_pt) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SETUP;
                  if ({1'b0, r_ff} == nr_ff - 1'b1) begin
                     r_in = '0;
                     c_in = c_ff + 1'b1;
                  end else begin
                     r_in = r_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_EDGE;
         idx_ff        <= '0;
         half_ff       <= 1'b0;
         c_ff          <= '0;
         r_ff          <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         half_ff       <= half_in;
         c_ff          <= c_in;
         r_ff          <= r_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cor_ff      <= cor_in;
      nc_ff       <= nc_in;
      nr_ff       <= nr_in;
      fp1x_ff     <= fp1x_in;
      fp1y_ff     <= fp1y_in;
      fp2x_ff     <= fp2x_in;
      fp2y_ff     <= fp2y_in;
      gslope_ff   <= gslope_in;
      goff_ff     <= goff_in;
      gvert_ff    <= gvert_in;
      fneg_ff     <= fneg_in;
      sp0x_ff     <= sp0x_in;
      sp0y_ff     <= sp0y_in;
      sp1x_ff     <= sp1x_in;
      sp1y_ff     <= sp1y_in;
      sl_slope_ff <= sl_slope_in;
      sl_off_ff   <= sl_off_in;
      sl_vert_ff  <= sl_vert_in;
      sk_ff       <= sk_in;
      sn_ff       <= sn_in;
      lneg_ff     <= lneg_in;
      lv_ff       <= lv_in;
      cs_ff       <= cs_in;
      co_ff       <= co_in;
      cv_ff       <= cv_in;
      rs_ff       <= rs_in;
      ro_ff       <= ro_in;
      rv_ff       <= rv_in;
      px_ff       <= px_in;
      base_ff     <= base_in;
      rsp_item_ff <= rsp_item_in;
   end

   // line tables, written once per fit
   always_ff @(posedge clock) begin
      if (state_ff == S_STORE) begin
         case (phase_ff)
            PH_EDGE: begin
               edge_slope_ff[idx_ff[1:0]] <= gslope_ff;
               edge_off_ff[idx_ff[1:0]]   <= goff_ff;
               edge_vert_ff[idx_ff[1:0]]  <= gvert_ff;
            end
            PH_COL: begin
               col_slope_ff[idx_ff] <= gslope_ff;
               col_off_ff[idx_ff]   <= goff_ff;
               col_vert_ff[idx_ff]  <= gvert_ff;
            end
            PH_ROW: begin
               row_slope_ff[idx_ff] <= gslope_ff;
               row_off_ff[idx_ff]   <= goff_ff;
               row_vert_ff[idx_ff]  <= gvert_ff;
            end
            default: begin
            end
         endcase
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

endmodule

FILE: hdl/quad_grid_point_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_grid_point_generator
// Grid of line intersections inside a quadrilateral, Q16.16 in and out.
// ----------------------------------------------------------------------------
//  channel  ports                               handshake
//  -------  ----------------------------------  ------------------------------
//  request  start, busy, req_item               taken when start && !busy
//  result   rsp_strobe, rsp_item                one cycle per beat, no stall
//  config   psel, penable, pwrite, paddr, ...   APB write, pready always high
//
//  The run time of one quadrilateral is set by the shared divider and
//  multiplier, each resolving one bit per cycle over 64 steps. busy stays
//  high from the accepted beat until the last result. Reset clears control
//  state and sets both counts to 8; there is no clearing pass. The result
//  side cannot stall.
// ----------------------------------------------------------------------------
module quad_grid_point_generator
   import qgpg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [2:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   logic [CNT_W-1:0] cols_ff, cols_in;
   logic [CNT_W-1:0] rows_ff, rows_in;
   logic [CNT_W-1:0] n_cols, n_rows;
   mul_req_type      mul_req;
   mul_rsp_type      mul_rsp;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (psel && penable && pwrite && pready) begin
         if ((paddr & CSR_ROWS_ADDR) == CSR_ROWS_ADDR) begin
            rows_in = pwdata[CNT_W-1:0];
         end else begin
            cols_in = pwdata[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CNT_W'(MAX_COLS);
         rows_ff <= CNT_W'(MAX_ROWS);
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   assign prdata = (paddr == CSR_COLS_ADDR) ? 32'(cols_ff)
                 : ((paddr & CSR_ROWS_ADDR) == CSR_ROWS_ADDR) ? 32'(rows_ff)
                 : 32'(cols_ff);
   assign pready = 1'b1;
   assign n_cols = eff_count(cols_ff, CNT_W'(MAX_COLS));
   assign n_rows = eff_count(rows_ff, CNT_W'(MAX_ROWS));

   qgpg_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .n_cols     (n_cols),
      .n_rows     (n_rows),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .mul_req    (mul_req),
      .mul_rsp    (mul_rsp),
      .div_req    (div_req),
      .div_rsp    (div_rsp)
   );

   qgpg_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   qgpg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

FILE: hdl/qgpg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qgpg_checker
// Port-level checks on run framing, bound to the generator top level.
// ----------------------------------------------------------------------------
`include "quad_grid_point_generator_defines.svh"

module qgpg_checker
   import qgpg_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input rsp_item_type rsp_item
);

   `QGPG_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "accepted beat did not raise busy")
   `QGPG_ASSERT_SAME(a_rsp_in_run, clock, reset, rsp_strobe, $past(busy), "result beat outside a run")
   `QGPG_ASSERT_SAME(a_last_ends, clock, reset, rsp_strobe && rsp_item.last, !busy, "busy after last beat")
   `QGPG_ASSERT_SAME(a_fail_last, clock, reset, rsp_strobe && rsp_item.failed, rsp_item.last && rsp_item.point_x == 0 && rsp_item.point_y == 0, "failed beat malformed")

endmodule

bind quad_grid_point_generator qgpg_checker u_qgpg_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

FILE: tb/quad_grid_point_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_grid_point_generator_tb
// Drives quadrilaterals through the grid point generator under a range of
// column and row counts. A scoreboard predicts every intersection point in
// Q16.16 and checks each result beat as it leaves the block.
// ----------------------------------------------------------------------------
module quad_grid_point_generator_tb;
   import qgpg_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint S64_MIN = 64'sh8000_0000_0000_0000;

   typedef struct {
      longint slope;
      longint offset;
      bit     vert;
   } grid_line_type;

   typedef struct {
      longint x;
      longint y;
   } grid_pt_type;

   class grid_scoreboard;
      bit [3:0]     cols_reg = 4'd8;
      bit [3:0]     rows_reg = 4'd8;
      rsp_item_type expected_points[$];
      int           errors;
      int           quads_seen;
      int           points_checked;

      function bit [63:0] magnitude(longint v);
         return v < 0 ? 64'(-v) : 64'(v);
      endfunction

      function longint signed_of(bit neg, bit [63:0] m);
         if (!neg) return m[63] ? S64_MAX : longint'(m);
         if (m[63]) return S64_MIN;
         return -longint'(m);
      endfunction

      function bit [63:0] gap(longint a, longint b, output bit neg);
         neg = a < b;
         return neg ? 64'(b - a) : 64'(a - b);
      endfunction

      function longint clamp_add(longint a, longint b);
         logic signed [64:0] s;
         s = {a[63], a} + {b[63], b};
         if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
         return s[63:0];
      endfunction

      function longint clamp32(longint v);
         if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
         if (v < -64'sh8000_0000) return -64'sh8000_0000;
         return v;
      endfunction

      // product of a Q32.32 slope and a Q16.16 value, shifted down by 32
      function longint scaled_mul(longint a, longint b);
         bit [127:0] p;
         bit         neg;
         neg = (a < 0) != (b < 0);
         p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
         if (p[127:96] != 0) return neg ? S64_MIN : S64_MAX;
         return signed_of(neg, p[95:32]);
      endfunction

      function longint scaled_div(bit [63:0] nm, bit nneg, bit [63:0] dm, bit dneg);
         bit [127:0] q;
         bit [63:0]  quot;
         if (dm == 0 || (nm >> 32) >= dm) begin
            quot = '1;
         end else begin
            q = {32'd0, nm, 32'd0} / {64'd0, dm};
            quot = q[63:0];
         end
         return signed_of(nneg != dneg, quot);
      endfunction

      function grid_line_type line_through(grid_pt_type p1, grid_pt_type p2);
         grid_line_type l;
         bit            nneg, dneg;
         bit [63:0]     nm, dm;
         if (p1.x == p2.x) begin
            l.vert = 1; l.slope = 0; l.offset = p1.x;
            return l;
         end
         nm = gap(p2.y, p1.y, nneg);
         dm = gap(p2.x, p1.x, dneg);
         l.vert = 0;
         l.slope = scaled_div(nm, nneg, dm, dneg);
         l.offset = clamp_add(p2.y, 0);
         begin
            logic signed [64:0] s;
            longint m;
            m = scaled_mul(l.slope, p2.x);
            s = {p2.y[63], p2.y} - {m[63], m};
            l.offset = (s[64] != s[63]) ? (s[64] ? S64_MIN : S64_MAX) : s[63:0];
         end
         return l;
      endfunction

      function longint interp(longint v1, longint v2, longint k, longint n);
         if (k >= n - 1) return v2;
         return v1 + (k * (v2 - v1)) / (n - 1);
      endfunction

      function grid_pt_type edge_point(grid_pt_type p0, grid_pt_type p1,
                                       grid_line_type l, longint k, longint n);
         grid_pt_type s;
         if (l.vert) begin
            s.x = p0.x;
            s.y = interp(p0.y, p1.y, k, n);
         end else begin
            s.x = interp(p0.x, p1.x, k, n);
            s.y = clamp32(clamp_add(scaled_mul(l.slope, s.x), l.offset));
         end
         return s;
      endfunction

      function longint count_of(bit [3:0] v);
         if (v == 0) return 1;
         return v > 8 ? 8 : v;
      endfunction

      function void note_item(req_item_type it);
         grid_pt_type   pa, pb, pc, pd;
         grid_line_type lab, lbc, ldc, lad;
         grid_line_type col_l[8], row_l[8];
         longint        nc, nr, x, y;
         bit            nneg, dneg, fail;
         bit [63:0]     nm, dm;
         rsp_item_type  e;
         quads_seen++;
         nc = count_of(cols_reg);
         nr = count_of(rows_reg);
         pa.x = it.a_x; pa.y = it.a_y; pb.x = it.b_x; pb.y = it.b_y;
         pc.x = it.c_x; pc.y = it.c_y; pd.x = it.d_x; pd.y = it.d_y;
         lab = line_through(pa, pb);
         lbc = line_through(pb, pc);
         ldc = line_through(pd, pc);
         lad = line_through(pa, pd);
         for (int c = 0; c < nc; c++)
            col_l[c] = line_through(edge_point(pa, pb, lab, c, nc),
                                    edge_point(pd, pc, ldc, c, nc));
         for (int r = 0; r < nr; r++)
            row_l[r] = line_through(edge_point(pb, pc, lbc, r, nr),
                                    edge_point(pa, pd, lad, r, nr));
         for (int c = 0; c < nc; c++) begin
            for (int r = 0; r < nr; r++) begin
               fail = 0; x = 0; y = 0;
               if (col_l[c].vert && row_l[r].vert) begin
                  fail = 1;
               end else if (col_l[c].vert) begin
                  x = col_l[c].offset;
                  y = clamp_add(scaled_mul(row_l[r].slope, x), row_l[r].offset);
               end else if (row_l[r].vert) begin
                  x = row_l[r].offset;
                  y = clamp_add(scaled_mul(col_l[c].slope, x), col_l[c].offset);
               end else if (col_l[c].slope == row_l[r].slope) begin
                  fail = 1;
               end else begin
                  nm = gap(row_l[r].offset, col_l[c].offset, nneg);
                  dm = gap(col_l[c].slope, row_l[r].slope, dneg);
                  x = scaled_div(nm, nneg, dm, dneg);
                  y = clamp_add(scaled_mul(col_l[c].slope, x), col_l[c].offset);
               end
               if (fail) begin
                  e.point_x = 0; e.point_y = 0; e.failed = 1; e.last = 1;
                  expected_points.push_back(e);
                  return;
               end
               e.point_x = 32'(clamp32(x));
               e.point_y = 32'(clamp32(y));
               e.failed = 0;
               e.last = (c == nc - 1 && r == nr - 1);
               expected_points.push_back(e);
            end
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type e;
         if (expected_points.size() == 0) begin
            $error("result beat with nothing expected: %p", got);
            errors++;
            return;
         end
         e = expected_points.pop_front();
         points_checked++;
         if (got.point_x !== e.point_x) begin
            $error("point_x expected %h got %h", e.point_x, got.point_x);
            errors++;
         end
         if (got.point_y !== e.point_y) begin
            $error("point_y expected %h got %h", e.point_y, got.point_y);
            errors++;
         end
         if (got.failed !== e.failed) begin
            $error("failed expected %b got %b", e.failed, got.failed);
            errors++;
         end
         if (got.last !== e.last) begin
            $error("last expected %b got %b", e.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   logic         psel, penable, pwrite;
   logic [2:0]   paddr;
   logic [31:0]  pwdata;
   logic [31:0]  prdata;
   logic         pready;

   grid_scoreboard sb = new();
   int             idle_cycles;
   int             settings_run;

   quad_grid_point_generator i_dut (
      .clock, .reset, .start, .busy, .req_item, .rsp_strobe, .rsp_item,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_item);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_quad(req_item_type it);
      @(negedge clock);
      start <= 1;
      req_item <= it;
      do @(posedge clock); while (busy);
      sb.note_item(it);
   endtask

   // drop start and hold until every point has come out
   task automatic wait_idle();
      @(negedge clock);
      start <= 0;
      while (sb.expected_points.size() != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      if (addr == CSR_COLS_ADDR) sb.cols_reg = data[3:0];
      else sb.rows_reg = data[3:0];
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic set_grid(logic [3:0] cols, logic [3:0] rows);
      wait_idle();
      csr_write(CSR_COLS_ADDR, {$urandom} << 4 | cols);
      csr_write(CSR_ROWS_ADDR, {$urandom} << 4 | rows);
      settings_run++;
   endtask

   function automatic req_item_type quad_of(int ax, int ay, int bx, int by,
                                            int cx, int cy, int dx, int dy);
      req_item_type q;
      q = '{ax, ay, bx, by, cx, cy, dx, dy};
      return q;
   endfunction

   function automatic req_item_type random_quad();
      req_item_type q;
      int           mode, sz, ox, oy;
      mode = $urandom_range(0, 9);
      sz = 1 << $urandom_range(12, 26);
      ox = $urandom_range(0, 2 * sz) - sz;
      oy = $urandom_range(0, 2 * sz) - sz;
      if (mode == 8) begin
         q = {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
      end else begin
         // roughly convex quad: A low-left, B up, C up-right, D right
         q.a_x = ox + $urandom_range(0, sz / 4);
         q.a_y = oy + $urandom_range(0, sz / 4);
         q.b_x = ox + $urandom_range(0, sz / 4);
         q.b_y = oy + sz - $urandom_range(0, sz / 4);
         q.c_x = ox + sz - $urandom_range(0, sz / 4);
         q.c_y = oy + sz - $urandom_range(0, sz / 4);
         q.d_x = ox + sz - $urandom_range(0, sz / 4);
         q.d_y = oy + $urandom_range(0, sz / 4);
         if (mode == 7) begin
            q.b_x = q.a_x;
            q.c_x = q.d_x;
         end
      end
      if (mode == 9) begin
         q.c_x = q.b_x; q.c_y = q.b_y;
      end
      return q;
   endfunction

   task automatic run_random(int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(1, 5);
         for (int i = 0; i < burst && n > 0; i++, n--) send_quad(random_quad());
         if ($urandom_range(0, 3) != 0) begin
            @(negedge clock);
            start <= 0;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
   endtask

   localparam int ONE = 32'h0001_0000;
   localparam int IMAX = 32'h7FFF_FFFF;
   localparam int IMIN = 32'h8000_0000;

   initial begin
      reset = 1; start = 0; req_item = '0;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      idle_cycles = 0; settings_run = 1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // reset counts: full eight by eight grid
      send_quad(quad_of(0, 0, 0, 8 * ONE, 8 * ONE, 8 * ONE, 8 * ONE, 0));
      send_quad(quad_of(-ONE, -2 * ONE, ONE / 3, 5 * ONE, 7 * ONE, 6 * ONE,
                        6 * ONE, -ONE));

      set_grid(4'd2, 4'd3);
      send_quad(quad_of(0, 0, 0, ONE, ONE, ONE, ONE, 0));
      send_quad(quad_of(0, 0, ONE, ONE, 3 * ONE, 3 * ONE, 2 * ONE, 2 * ONE));
      send_quad(quad_of(5, 5, 5, 5, 5, 5, 5, 5));
      send_quad('0);
      send_quad(quad_of(IMIN, IMIN, IMIN, IMAX, IMAX, IMAX, IMAX, IMIN));
      send_quad(quad_of(IMAX, IMIN, IMIN, IMAX, IMAX, IMAX, IMIN, IMIN));
      send_quad('1);
      send_quad(quad_of(IMIN, 0, 1, IMAX, IMAX, -1, 0, IMIN));

      // single sample per edge, then a zero count and an oversized one
      set_grid(4'd1, 4'd1);
      send_quad(quad_of(0, 0, ONE, 3 * ONE, 4 * ONE, 2 * ONE, 3 * ONE, -ONE));
      send_quad(quad_of(0, 0, 0, ONE, ONE, ONE, ONE, 0));
      set_grid(4'd0, 4'd15);
      send_quad(quad_of(0, 0, ONE, 3 * ONE, 4 * ONE, 2 * ONE, 3 * ONE, -ONE));
      set_grid(4'd15, 4'd0);
      send_quad(quad_of(0, 0, 0, 2 * ONE, 3 * ONE, 2 * ONE, 3 * ONE, ONE));

      set_grid(4'd2, 4'd2);
      run_random(20);
      set_grid(4'd1, 4'd3);
      run_random(10);
      wait_idle();                    // hold off until the grid has drained
      run_random(10);
      set_grid(4'd3, 4'd2);
      run_random(20);
      set_grid(4'd8, 4'd1);
      run_random(15);
      set_grid(4'd1, 4'd8);
      run_random(15);
      set_grid(4'd3, 4'd3);
      run_random(20);
      set_grid(4'd0, 4'd2);
      run_random(20);
      set_grid(4'd2, 4'd4);
      run_random(20);
      set_grid(4'd8, 4'd8);
      run_random(5);
      set_grid(4'd9, 4'd1);
      run_random(20);

      wait_idle();
      repeat (200) @(posedge clock);
      if (sb.expected_points.size() != 0) begin
         $error("%0d expected points never arrived", sb.expected_points.size());
         sb.errors++;
      end
      $display("covered %0d quadrilaterals over %0d grid settings", sb.quads_seen,
               settings_run);
      $display("%0d intersection points compared, %0d field errors", sb.points_checked,
               sb.errors);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/qgpg_pkg.sv
hdl/qgpg_mul.sv
hdl/qgpg_div.sv
hdl/qgpg_seq.sv
hdl/quad_grid_point_generator.sv
hdl/qgpg_checker.sv
tb/quad_grid_point_generator_tb.sv
